[sv/tpd_pkg.sv]
// Package for the touch packet decoder: field widths, codes, register
// indexes and reset values. No dependencies.
package tpd_pkg;

    localparam int FIELD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int NLANE      = 4;
    localparam int DIV_STEPS  = FIELD_W;
    localparam int PROD_W     = 2 * FIELD_W;
    localparam int COORD_BITS = 12;

    localparam logic [BYTE_W-1:0] HDR_COORD  = 8'h5a;
    localparam logic [BYTE_W-1:0] ST_RELEASE = 8'h01;

    localparam logic [FIELD_W-1:0] RST_WIDTH     = 12'd600;
    localparam logic [FIELD_W-1:0] RST_HEIGHT    = 12'd800;
    localparam logic [FIELD_W-1:0] RST_SPAN_LOW  = 12'd768;
    localparam logic [FIELD_W-1:0] RST_SPAN_HIGH = 12'd1088;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 8'd0,
        REG_SCREEN_HEIGHT = 8'd1,
        REG_RAW_SPAN_LOW  = 8'd2,
        REG_RAW_SPAN_HIGH = 8'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ONE     = 2'd2,
        KIND_TWO     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FING_NONE = 2'd0,
        FING_ONE  = 2'd1,
        FING_TWO  = 2'd2,
        FING_BAD  = 2'd3
    } t_fingers;

endpackage

[sv/touch_packet_decoder.sv]
// Touch packet decoder top level: decode, scale multiply, 12-step pipelined
// divider over four lanes, output register. Uses tpd_pkg.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+--------------------------------------
//  in      | i_valid     | o_ready      | i_header_byte .. i_status_byte
//  out     | o_valid     | i_ready      | o_report_kind, o_first_x .. o_second_down
//  cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls. From accept to result: decode stage, multiply
// stage, one stage per quotient bit of the restoring divider, output register.
// All stages advance together; a stalled output freezes the whole pipe and
// o_ready drops, so nothing is lost or repeated. Reset clears valid bits and
// loads the default screen size and raw spans. Config writes are always taken.
module touch_packet_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_header_byte,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair1_nibbles,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair1_a_low,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair1_b_low,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair2_nibbles,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair2_a_low,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_pair2_b_low,
    input  logic [tpd_pkg::BYTE_W-1:0]     i_status_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_report_kind,
    output logic [tpd_pkg::FIELD_W-1:0]    o_first_x,
    output logic [tpd_pkg::FIELD_W-1:0]    o_first_y,
    output logic [tpd_pkg::FIELD_W-1:0]    o_second_x,
    output logic [tpd_pkg::FIELD_W-1:0]    o_second_y,
    output logic                           o_touch_down,
    output logic                           o_second_down,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpd_pkg::FIELD_W-1:0]    i_cfg_data
);
    import tpd_pkg::*;

    localparam logic [16:0] COORD_LIM = 17'((1 << COORD_BITS) - 1);

    logic [FIELD_W-1:0] r_width, r_height, r_span_lo, r_span_hi;

    logic en;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_span_lo <= RST_SPAN_LOW;
            r_span_hi <= RST_SPAN_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width   <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height  <= i_cfg_data;
                REG_RAW_SPAN_LOW:  r_span_lo <= i_cfg_data;
                REG_RAW_SPAN_HIGH: r_span_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- decode stage
    logic                r_a_v;
    logic [1:0]          r_a_kind;
    logic [FIELD_W-1:0]  r_a_raw [NLANE];
    logic [1:0]          n_a_kind;
    logic                any_nz;

    always_comb begin
        any_nz = |{i_pair1_nibbles, i_pair1_a_low, i_pair1_b_low,
                   i_pair2_nibbles, i_pair2_a_low, i_pair2_b_low};
        n_a_kind = KIND_NONE;
        if (i_header_byte == HDR_COORD) begin
            unique case (t_fingers'(i_status_byte[2:1]))
                FING_NONE: if (i_status_byte == ST_RELEASE && !any_nz)
                               n_a_kind = KIND_RELEASE;
                FING_ONE:  n_a_kind = KIND_ONE;
                FING_TWO:  n_a_kind = KIND_TWO;
                FING_BAD:  n_a_kind = KIND_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en)  r_a_v <= i_valid;
    end

    // lanes: 0 x1 (low nibble), 1 y1 (high nibble), 2 x2, 3 y2
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_kind   <= n_a_kind;
            r_a_raw[0] <= {i_pair1_nibbles[3:0], i_pair1_b_low};
            r_a_raw[1] <= {i_pair1_nibbles[7:4], i_pair1_a_low};
            r_a_raw[2] <= {i_pair2_nibbles[3:0], i_pair2_b_low};
            r_a_raw[3] <= {i_pair2_nibbles[7:4], i_pair2_a_low};
        end
    end

    // ---- multiply stage feeds divider slot 0; slots 1..DIV_STEPS each add a bit
    logic               r_dv    [DIV_STEPS+1];
    logic [1:0]         r_dkind [DIV_STEPS+1];
    logic [NLANE-1:0]   r_dsat  [DIV_STEPS+1];
    logic [FIELD_W-1:0] r_drem  [DIV_STEPS+1][NLANE];
    logic [FIELD_W-1:0] r_dlow  [DIV_STEPS+1][NLANE];
    logic [FIELD_W-1:0] r_dq    [DIV_STEPS+1][NLANE];

    logic [FIELD_W-1:0] divisor [NLANE];
    logic [NLANE-1:0]   n_sat;
    logic [PROD_W-1:0]  n_prod  [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (l % 2 == 0) begin
                divisor[l] = r_span_lo;
                n_sat[l]   = r_a_raw[l] >= r_span_lo;
                n_prod[l]  = PROD_W'(r_width) * PROD_W'(r_a_raw[l]);
            end else begin
                divisor[l] = r_span_hi;
                n_sat[l]   = r_a_raw[l] >= r_span_hi;
                n_prod[l]  = PROD_W'(r_height) * PROD_W'(r_span_hi - r_a_raw[l]);
            end
        end
    end

    logic [FIELD_W-1:0] n_rem [DIV_STEPS+1][NLANE];
    logic [FIELD_W-1:0] n_q   [DIV_STEPS+1][NLANE];
    logic [FIELD_W:0]   trial [DIV_STEPS+1][NLANE];
    logic [FIELD_W:0]   diff  [DIV_STEPS+1][NLANE];

    always_comb begin
        for (int s = 0; s <= DIV_STEPS; s++) begin
            for (int l = 0; l < NLANE; l++) begin
                trial[s][l] = '0;
                diff[s][l]  = '0;
                n_rem[s][l] = '0;
                n_q[s][l]   = '0;
            end
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            for (int l = 0; l < NLANE; l++) begin
                trial[s][l] = {r_drem[s-1][l], r_dlow[s-1][l][FIELD_W-1]};
                diff[s][l]  = trial[s][l] - {1'b0, divisor[l]};
                if (trial[s][l] >= {1'b0, divisor[l]}) begin
                    n_rem[s][l] = diff[s][l][FIELD_W-1:0];
                    n_q[s][l]   = {r_dq[s-1][l][FIELD_W-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = trial[s][l][FIELD_W-1:0];
                    n_q[s][l]   = {r_dq[s-1][l][FIELD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_a_v;
            for (int s = 1; s <= DIV_STEPS; s++) r_dv[s] <= r_dv[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dkind[0] <= r_a_kind;
            r_dsat[0]  <= n_sat;
            for (int l = 0; l < NLANE; l++) begin
                r_drem[0][l] <= n_prod[l][PROD_W-1:FIELD_W];
                r_dlow[0][l] <= n_prod[l][FIELD_W-1:0];
                r_dq[0][l]   <= '0;
            end
            for (int s = 1; s <= DIV_STEPS; s++) begin
                r_dkind[s] <= r_dkind[s-1];
                r_dsat[s]  <= r_dsat[s-1];
                for (int l = 0; l < NLANE; l++) begin
                    r_drem[s][l] <= n_rem[s][l];
                    r_dlow[s][l] <= {r_dlow[s-1][l][FIELD_W-2:0], 1'b0};
                    r_dq[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    // ---- output register
    logic [FIELD_W-1:0] r_o_coord [NLANE];
    logic [FIELD_W-1:0] n_coord   [NLANE];
    logic [FIELD_W-1:0] val       [NLANE];
    logic [1:0]         r_o_kind;
    logic               r_ov;
    logic [1:0]         fkind;

    always_comb begin
        fkind = r_dkind[DIV_STEPS];
        for (int l = 0; l < NLANE; l++) begin
            if (r_dsat[DIV_STEPS][l]) val[l] = (l % 2 == 0) ? r_width : '0;
            else                      val[l] = r_dq[DIV_STEPS][l];
            if ({5'b0, val[l]} > COORD_LIM) val[l] = COORD_LIM[FIELD_W-1:0];
            if (l < 2) n_coord[l] = (fkind == KIND_ONE || fkind == KIND_TWO) ? val[l] : '0;
            else       n_coord[l] = (fkind == KIND_TWO) ? val[l] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= r_dv[DIV_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_kind <= fkind;
            for (int l = 0; l < NLANE; l++) r_o_coord[l] <= n_coord[l];
        end
    end

    assign o_valid       = r_ov;
    assign o_report_kind = r_o_kind;
    assign o_first_x     = r_o_coord[0];
    assign o_first_y     = r_o_coord[1];
    assign o_second_x    = r_o_coord[2];
    assign o_second_y    = r_o_coord[3];
    assign o_touch_down  = (r_o_kind == KIND_ONE) || (r_o_kind == KIND_TWO);
    assign o_second_down = (r_o_kind == KIND_TWO);

endmodule

[verif/touch_packet_decoder_test.sv]
// Self-checking testbench for touch_packet_decoder: directed and random packets,
// register settings and random back-pressure, checked against a behavioral decoder.
// Depends on tpd_pkg and touch_packet_decoder.
module touch_packet_decoder_test;
    import tpd_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 8'd9;
    localparam logic [FIELD_W-1:0] COORD_MAX = FIELD_W'((1 << COORD_BITS) - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] p1_nib;
        logic [BYTE_W-1:0] p1_a;
        logic [BYTE_W-1:0] p1_b;
        logic [BYTE_W-1:0] p2_nib;
        logic [BYTE_W-1:0] p2_a;
        logic [BYTE_W-1:0] p2_b;
        logic [BYTE_W-1:0] status;
    } t_packet;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] fx;
        logic [FIELD_W-1:0] fy;
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic               td;
        logic               sd;
    } t_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_header_byte = '0;
    logic [BYTE_W-1:0]    i_pair1_nibbles = '0;
    logic [BYTE_W-1:0]    i_pair1_a_low = '0;
    logic [BYTE_W-1:0]    i_pair1_b_low = '0;
    logic [BYTE_W-1:0]    i_pair2_nibbles = '0;
    logic [BYTE_W-1:0]    i_pair2_a_low = '0;
    logic [BYTE_W-1:0]    i_pair2_b_low = '0;
    logic [BYTE_W-1:0]    i_status_byte = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_report_kind;
    logic [FIELD_W-1:0]   o_first_x;
    logic [FIELD_W-1:0]   o_first_y;
    logic [FIELD_W-1:0]   o_second_x;
    logic [FIELD_W-1:0]   o_second_y;
    logic                 o_touch_down;
    logic                 o_second_down;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    touch_packet_decoder dut (.*);

    // decoder copy of the registers
    logic [FIELD_W-1:0] scr_w, scr_h, span_lo, span_hi;

    t_report report_q[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle = 0;
    int      stall_pct = 0;
    logic    holding = 1'b0;
    event    hold_go;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (holding)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always begin
        @(hold_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    function automatic void scale_point(input logic [7:0] nib, input logic [7:0] a,
                                        input logic [7:0] b, output logic [FIELD_W-1:0] x,
                                        output logic [FIELD_W-1:0] y);
        logic [31:0] hi_raw, lo_raw, xv, yv;
        hi_raw = 32'({nib[7:4], a});
        lo_raw = 32'({nib[3:0], b});
        if (lo_raw >= 32'(span_lo)) xv = 32'(scr_w);
        else xv = (32'(scr_w) * lo_raw) / 32'(span_lo);
        if (hi_raw >= 32'(span_hi)) yv = '0;
        else yv = (32'(scr_h) * (32'(span_hi) - hi_raw)) / 32'(span_hi);
        x = (xv > 32'(COORD_MAX)) ? COORD_MAX : xv[FIELD_W-1:0];
        y = (yv > 32'(COORD_MAX)) ? COORD_MAX : yv[FIELD_W-1:0];
    endfunction

    function automatic t_report decode_packet(input t_packet p);
        t_report  r;
        t_fingers f;
        r = '0;
        r.kind = KIND_NONE;
        f = t_fingers'(p.status[2:1]);
        if (p.header == HDR_COORD) begin
            case (f)
                FING_NONE: begin
                    if (p.status == ST_RELEASE && (p.p1_nib | p.p1_a | p.p1_b |
                        p.p2_nib | p.p2_a | p.p2_b) == '0)
                        r.kind = KIND_RELEASE;
                end
                FING_ONE: begin
                    r.kind = KIND_ONE;
                    scale_point(p.p1_nib, p.p1_a, p.p1_b, r.fx, r.fy);
                    r.td = 1'b1;
                end
                FING_TWO: begin
                    r.kind = KIND_TWO;
                    scale_point(p.p1_nib, p.p1_a, p.p1_b, r.fx, r.fy);
                    scale_point(p.p2_nib, p.p2_a, p.p2_b, r.sx, r.sy);
                    r.td = 1'b1;
                    r.sd = 1'b1;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {t_kind'(o_report_kind), o_first_x, o_first_y, o_second_x, o_second_y,
                   o_touch_down, o_second_down};
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report %p", got);
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // called right after the rising clock; returns right after the packet has been accepted
    task automatic send_packet(input t_packet p);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_header_byte   <= p.header;
        i_pair1_nibbles <= p.p1_nib;
        i_pair1_a_low   <= p.p1_a;
        i_pair1_b_low   <= p.p1_b;
        i_pair2_nibbles <= p.p2_nib;
        i_pair2_a_low   <= p.p2_a;
        i_pair2_b_low   <= p.p2_b;
        i_status_byte   <= p.status;
        do @(posedge i_clk); while (!o_ready);
        report_q.push_back(decode_packet(p));
    endtask

    task automatic wait_drained();
        if (i_valid) i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    // leaves i_cfg_valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = val;
            REG_SCREEN_HEIGHT: scr_h = val;
            REG_RAW_SPAN_LOW:  span_lo = val;
            REG_RAW_SPAN_HIGH: span_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_screen(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] h,
                              input logic [FIELD_W-1:0] slo, input logic [FIELD_W-1:0] shi);
        wait_drained();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_RAW_SPAN_LOW, slo);
        write_reg(REG_RAW_SPAN_HIGH, shi);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_packet make_packet(input logic [7:0] hdr, input logic [7:0] fill,
                                            input logic [7:0] st);
        return {hdr, fill, fill, fill, fill, fill, fill, st};
    endfunction

    function automatic t_packet rand_packet();
        t_packet p;
        int      pick;
        p = {$urandom, $urandom};
        pick = $urandom_range(99);
        p.header = HDR_COORD;
        if (pick < 10) begin
            p.header = 8'($urandom);
        end else if (pick < 20) begin
            p = make_packet(HDR_COORD, 8'h00, ST_RELEASE);
        end else if (pick < 27) begin
            // nearly a release: one stray byte or stray status bits
            p = make_packet(HDR_COORD, 8'h00, ST_RELEASE);
            if ($urandom_range(1))
                p.status = {5'($urandom_range(31)), 2'b00, 1'($urandom)};
            else
                p[8*$urandom_range(1, 6) +: 8] = 8'($urandom_range(1, 255));
        end else if (pick < 60) begin
            p.status[2:1] = FING_ONE;
        end else if (pick < 95) begin
            p.status[2:1] = FING_TWO;
        end else begin
            p.status[2:1] = FING_BAD;
        end
        return p;
    endfunction

    task automatic test_directed();
        t_packet p;
        send_packet(make_packet(8'h00, 8'h00, 8'h02));
        send_packet(make_packet(8'hff, 8'hff, 8'h04));
        send_packet(make_packet(8'h5b, 8'h12, 8'h02));
        send_packet(make_packet(HDR_COORD, 8'h00, ST_RELEASE));
        send_packet(make_packet(HDR_COORD, 8'h00, 8'h00));
        send_packet(make_packet(HDR_COORD, 8'h00, 8'h09));
        send_packet(make_packet(HDR_COORD, 8'h00, 8'hf9));
        p = make_packet(HDR_COORD, 8'h00, ST_RELEASE);
        p.p2_b = 8'h80;
        send_packet(p);
        p = make_packet(HDR_COORD, 8'h00, ST_RELEASE);
        p.p1_nib = 8'h01;
        send_packet(p);
        send_packet(make_packet(HDR_COORD, 8'h00, 8'h02));
        send_packet(make_packet(HDR_COORD, 8'hff, 8'hfb));
        send_packet(make_packet(HDR_COORD, 8'h00, 8'h04));
        send_packet(make_packet(HDR_COORD, 8'hff, 8'hfd));
        send_packet(make_packet(HDR_COORD, 8'h37, 8'h06));
        send_packet(make_packet(HDR_COORD, 8'hff, 8'hff));
        // raw values at, just below and just above the reset spans, then raw extremes
        p = {HDR_COORD, 8'h43, 8'h40, 8'h00, 8'h43, 8'h3f, 8'hff, 8'h04};
        send_packet(p);
        p = {HDR_COORD, 8'h42, 8'h41, 8'hff, 8'h00, 8'h00, 8'h01, 8'h04};
        send_packet(p);
        p = {HDR_COORD, 8'h0f, 8'h00, 8'hff, 8'hf0, 8'hff, 8'h00, 8'h04};
        send_packet(p);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        set_screen(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        repeat (50) send_packet(rand_packet());
        set_screen(12'd1, 12'd1, 12'd1, 12'd1);
        repeat (50) send_packet(rand_packet());
        set_screen(12'd4095, 12'd1, 12'd1, 12'd4095);
        repeat (50) send_packet(rand_packet());
        set_screen(FIELD_W'($urandom_range(1, 4095)), FIELD_W'($urandom_range(1, 4095)),
                   FIELD_W'($urandom_range(1, 4095)), FIELD_W'($urandom_range(1, 4095)));
        // write to an unused index must change nothing
        write_reg(REG_UNUSED_IDX, FIELD_W'($urandom));
        i_cfg_valid <= 1'b0;
        repeat (50) send_packet(rand_packet());
        wait_drained();
    endtask

    task automatic test_random_flow();
        int idle_set[4] = '{0, 50, 0, 22};
        int stall_set[4] = '{0, 0, 50, 22};
        for (int ph = 0; ph < 4; ph++) begin
            set_screen(FIELD_W'($urandom_range(1, 4095)), FIELD_W'($urandom_range(1, 4095)),
                       FIELD_W'($urandom_range(1, 4095)), FIELD_W'($urandom_range(1, 4095)));
            send_idle = idle_set[ph];
            stall_pct = stall_set[ph];
            repeat (220) send_packet(rand_packet());
        end
        wait_drained();
        send_idle = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_screen(RST_WIDTH, RST_HEIGHT, RST_SPAN_LOW, RST_SPAN_HIGH);
        -> hold_go;
        repeat (60) send_packet(rand_packet());
        wait_drained();
    endtask

    initial begin
        scr_w   = RST_WIDTH;
        scr_h   = RST_HEIGHT;
        span_lo = RST_SPAN_LOW;
        span_hi = RST_SPAN_HIGH;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_flow();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && report_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[sim.f]
sv/tpd_pkg.sv
sv/touch_packet_decoder.sv
verif/touch_packet_decoder_test.sv
